FILE: hdl/lps_pkg.sv
// Package for the LRU page replacement stack: default sizes, field widths,
// register map and the command bundle between controller and datapath.
// No dependencies.
package lps_pkg;

   localparam int MAX_FRAMES_DEF = 16;
   localparam int PAGE_BITS_DEF  = 16;

   localparam int PAGE_W  = 16;
   localparam int DEPTH_W = 4;
   localparam int OCC_W   = 5;
   localparam int TOTAL_W = 32;
   localparam int CFG_W   = 5;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 3;

   localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd3;

   // register index taken from paddr[2]
   localparam logic REG_FRAMES = 1'b0;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic commit;
   } lps_cmd_type;

endpackage

FILE: hdl/lps_csr.sv
// Configuration register block: frame limit register on an APB-style port.
// Depends on lps_pkg.
module lps_csr
   import lps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output logic [CFG_W-1:0]  frames
);

   logic [CFG_W-1:0] frames_ff;
   logic [CFG_W-1:0] frames_in;
   logic             wr_frames;

   assign pready    = 1'b1;
   assign wr_frames = psel && penable && pwrite && (paddr[2] == REG_FRAMES);
   assign frames_in = wr_frames ? pwdata[CFG_W-1:0] : frames_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= FRAMES_RESET;
      end else begin
         frames_ff <= frames_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_FRAMES) begin
         prdata[CFG_W-1:0] = frames_ff;
      end
   end

   assign frames = frames_ff;

endmodule

FILE: hdl/lps_ctrl.sv
// Controller: sequences capture, lookup and commit for one beat and owns the
// request ready and response valid flags. Depends on lps_pkg.
module lps_ctrl
   import lps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output lps_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_WRITE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOK;
            end
         end
         ST_LOOK: begin
            cmd.lookup = 1'b1;
            state_in   = ST_WRITE;
         end
         ST_WRITE: begin
            if (slot_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hdl/lps_datapath.sv
// Datapath: recency stack with parallel tag compare, eviction select,
// occupancy, saturating totals and response registers. Depends on lps_pkg.
module lps_datapath
   import lps_pkg::*;
#(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF,
   parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  lps_cmd_type        cmd,
   input  logic [CFG_W-1:0]   frames,
   input  logic [PAGE_W-1:0]  req_page_number,
   output logic               rsp_hit,
   output logic [DEPTH_W-1:0] rsp_hit_depth,
   output logic               rsp_evicted_valid,
   output logic [PAGE_W-1:0]  rsp_evicted_page,
   output logic [OCC_W-1:0]   rsp_occupancy,
   output logic [TOTAL_W-1:0] rsp_hit_total,
   output logic [TOTAL_W-1:0] rsp_fault_total
);

   localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   logic [PAGE_BITS-1:0] stack_ff [MAX_FRAMES];
   logic [CNT_W-1:0]     count_ff;
   logic [TOTAL_W-1:0]   hit_cnt_ff;
   logic [TOTAL_W-1:0]   fault_cnt_ff;
   logic [PAGE_BITS-1:0] page_ff;
   logic                 hit_ff;
   logic [IDX_W-1:0]     depth_ff;
   logic                 evict_ff;
   logic [PAGE_BITS-1:0] ev_page_ff;
   logic                 rsp_hit_ff;
   logic [DEPTH_W-1:0]   rsp_depth_ff;
   logic                 rsp_ev_valid_ff;
   logic [PAGE_W-1:0]    rsp_ev_page_ff;

   logic [PAGE_BITS+PAGE_W-1:0]  page_wide;
   logic [PAGE_BITS-1:0]         page_in;
   logic [LIM_W-1:0]             lim;
   logic [LIM_W-1:0]             lim_m1;
   logic [LIM_W-1:0]             frames_ext;
   logic                         full;
   logic [MAX_FRAMES-1:0]        match;
   logic                         hit_in;
   logic [IDX_W-1:0]             depth_in;
   logic [CNT_W-1:0]             ev_idx_wide;
   logic [IDX_W-1:0]             ev_idx;
   logic [CNT_W-1:0]             base_count;
   logic [CNT_W-1:0]             count_in;
   logic [IDX_W+DEPTH_W-1:0]     depth_wide;
   logic [CNT_W+OCC_W-1:0]       occ_wide;
   logic [PAGE_BITS+PAGE_W-1:0]  ev_wide;

   assign page_wide = {{PAGE_BITS{1'b0}}, req_page_number};
   assign page_in   = page_wide[PAGE_BITS-1:0];

   // frame limit: zero acts as one, clamp to stack depth
   assign frames_ext = LIM_W'(frames);
   always_comb begin
      if (frames == '0) begin
         lim = LIM_W'(1);
      end else if (frames_ext > LIM_W'(MAX_FRAMES)) begin
         lim = LIM_W'(MAX_FRAMES);
      end else begin
         lim = frames_ext;
      end
   end
   assign lim_m1 = lim - LIM_W'(1);
   assign full   = (LIM_W'(count_ff) >= lim);

   // parallel compare against resident entries, lowest depth wins
   always_comb begin
      hit_in   = 1'b0;
      depth_in = '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         match[i] = (CNT_W'(i) < count_ff) && (stack_ff[i] == page_ff);
      end
      for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_in   = 1'b1;
            depth_in = IDX_W'(i);
         end
      end
   end

   assign ev_idx_wide = count_ff - CNT_W'(1);
   assign ev_idx      = ev_idx_wide[IDX_W-1:0];

   assign base_count = evict_ff ? CNT_W'(lim_m1) : count_ff;
   assign count_in   = hit_ff ? count_ff : base_count + CNT_W'(1);

   assign depth_wide = {{DEPTH_W{1'b0}}, depth_ff};
   assign ev_wide    = {{PAGE_W{1'b0}}, ev_page_ff};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         page_ff <= page_in;
      end
      if (cmd.lookup) begin
         hit_ff     <= hit_in;
         depth_ff   <= depth_in;
         evict_ff   <= !hit_in && full;
         ev_page_ff <= stack_ff[ev_idx];
      end
      if (cmd.commit) begin
         stack_ff[0] <= page_ff;
         for (int i = 1; i < MAX_FRAMES; i++) begin
            if (!hit_ff || (IDX_W'(i) <= depth_ff)) begin
               stack_ff[i] <= stack_ff[i-1];
            end
         end
         rsp_hit_ff      <= hit_ff;
         rsp_depth_ff    <= hit_ff ? depth_wide[DEPTH_W-1:0] : '0;
         rsp_ev_valid_ff <= evict_ff;
         rsp_ev_page_ff  <= evict_ff ? ev_wide[PAGE_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         hit_cnt_ff   <= '0;
         fault_cnt_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
         if (hit_ff && (hit_cnt_ff != '1)) begin
            hit_cnt_ff <= hit_cnt_ff + TOTAL_W'(1);
         end
         if (!hit_ff && (fault_cnt_ff != '1)) begin
            fault_cnt_ff <= fault_cnt_ff + TOTAL_W'(1);
         end
      end
   end

   assign occ_wide = {{OCC_W{1'b0}}, count_ff};

   assign rsp_hit           = rsp_hit_ff;
   assign rsp_hit_depth     = rsp_depth_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_occupancy     = occ_wide[OCC_W-1:0];
   assign rsp_hit_total     = hit_cnt_ff;
   assign rsp_fault_total   = fault_cnt_ff;

endmodule

FILE: hdl/lru_page_replacement_stack_core.sv
// Top level of the LRU page replacement stack: controller, datapath and
// configuration register. Depends on lps_pkg, lps_csr, lps_ctrl, lps_datapath.
//
//   channel   direction  handshake               payload
//   req       in         req_valid / req_ready   req_page_number
//   rsp       out        rsp_valid / rsp_ready   hit, depth, eviction, occupancy, totals
//   csr       in/out     psel / penable / pready frame limit at byte address 0
//
// Each beat runs in order: capture, parallel tag compare with eviction
// select, then stack shift and counter update into the response register.
// A new request is taken once the previous beat has moved into the response
// register, even while that response still waits for rsp_ready.
// A held response stalls the commit step only. Synchronous reset empties the
// stack, zeroes both totals and sets the frame limit to 3; no clearing pass.
module lru_page_replacement_stack_core
   import lps_pkg::*;
#(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF,
   parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [PAGE_W-1:0]  req_page_number,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic [DEPTH_W-1:0] rsp_hit_depth,
   output logic               rsp_evicted_valid,
   output logic [PAGE_W-1:0]  rsp_evicted_page,
   output logic [OCC_W-1:0]   rsp_occupancy,
   output logic [TOTAL_W-1:0] rsp_hit_total,
   output logic [TOTAL_W-1:0] rsp_fault_total,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [ADDR_W-1:0]  paddr,
   input  logic [DATA_W-1:0]  pwdata,
   output logic [DATA_W-1:0]  prdata,
   output logic               pready
);

   lps_cmd_type      cmd;
   logic [CFG_W-1:0] frames;

   lps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .frames  (frames)
   );

   lps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   lps_datapath #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .frames            (frames),
      .req_page_number   (req_page_number),
      .rsp_hit           (rsp_hit),
      .rsp_hit_depth     (rsp_hit_depth),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_hit_total     (rsp_hit_total),
      .rsp_fault_total   (rsp_fault_total)
   );

endmodule

FILE: sim/lru_replacement_monitor.sv
`timescale 1ns / 100ps
// Scoreboard for lru_page_replacement_stack_core: follows frame-limit writes, predicts
// each response beat from accepted requests and compares it field by field.
// Depends on lps_pkg.
module lru_replacement_monitor
   import lps_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [PAGE_W-1:0]  req_page_number,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_hit,
   input  logic [DEPTH_W-1:0] rsp_hit_depth,
   input  logic               rsp_evicted_valid,
   input  logic [PAGE_W-1:0]  rsp_evicted_page,
   input  logic [OCC_W-1:0]   rsp_occupancy,
   input  logic [TOTAL_W-1:0] rsp_hit_total,
   input  logic [TOTAL_W-1:0] rsp_fault_total,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic               pready,
   input  logic [ADDR_W-1:0]  paddr,
   input  logic [DATA_W-1:0]  pwdata,
   output int                 outstanding,
   output int                 mismatch_count,
   output int                 hits_seen,
   output int                 faults_seen
);

   localparam int FRAME_SLOTS = MAX_FRAMES_DEF;

   typedef struct packed {
      logic               hit;
      logic [DEPTH_W-1:0] depth;
      logic               ev_valid;
      logic [PAGE_W-1:0]  ev_page;
      logic [OCC_W-1:0]   occ;
      logic [TOTAL_W-1:0] hits;
      logic [TOTAL_W-1:0] faults;
   } lru_outcome_type;

   logic [PAGE_W-1:0]  page_stack [FRAME_SLOTS];
   int                 resident;
   logic [TOTAL_W-1:0] hit_cnt;
   logic [TOTAL_W-1:0] fault_cnt;
   logic [CFG_W-1:0]   frame_reg;
   lru_outcome_type    due_outcomes [$];
   int                 errors;
   int                 hits_n;
   int                 faults_n;

   assign mismatch_count = errors;
   assign hits_seen      = hits_n;
   assign faults_seen    = faults_n;

   task automatic flag(input string what);
      errors++;
      $display("%0t: mismatch: %s", $time, what);
   endtask

   function automatic lru_outcome_type touch_page(input logic [PAGE_W-1:0] page);
      lru_outcome_type o;
      int              lim;
      int              depth;
      int              i;
      bit              found;
      o     = '0;
      found = 1'b0;
      depth = 0;
      lim   = (frame_reg == 0) ? 1 : (frame_reg > FRAME_SLOTS) ? FRAME_SLOTS : int'(frame_reg);
      for (i = 0; i < resident; i++) begin
         if (!found && page_stack[i] == page) begin
            found = 1'b1;
            depth = i;
         end
      end
      if (found) begin
         for (i = depth; i > 0; i--) page_stack[i] = page_stack[i-1];
         page_stack[0] = page;
         if (hit_cnt != '1) hit_cnt++;
      end else begin
         if (resident >= lim) begin
            o.ev_valid = 1'b1;
            o.ev_page  = page_stack[resident-1];
            resident   = lim - 1;
         end
         for (i = resident; i > 0; i--) page_stack[i] = page_stack[i-1];
         page_stack[0] = page;
         resident++;
         if (fault_cnt != '1) fault_cnt++;
      end
      o.hit    = found;
      o.depth  = DEPTH_W'(depth);
      o.occ    = OCC_W'(resident);
      o.hits   = hit_cnt;
      o.faults = fault_cnt;
      return o;
   endfunction

   always @(posedge clock) begin
      lru_outcome_type want;
      if (reset) begin
         resident  = 0;
         hit_cnt   = '0;
         fault_cnt = '0;
         frame_reg = FRAMES_RESET;
         foreach (page_stack[i]) page_stack[i] = '0;
         due_outcomes.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr[2] == REG_FRAMES) begin
            frame_reg = pwdata[CFG_W-1:0];
         end
         if (rsp_valid && rsp_ready) begin
            if (due_outcomes.size() == 0) begin
               flag("response beat with no request pending");
            end else begin
               want = due_outcomes.pop_front();
               if (rsp_hit)
                  hits_n++;
               else
                  faults_n++;
               if (rsp_hit !== want.hit)
                  flag($sformatf("hit got %0d want %0d", rsp_hit, want.hit));
               if (rsp_hit_depth !== want.depth)
                  flag($sformatf("hit_depth got %0d want %0d", rsp_hit_depth, want.depth));
               if (rsp_evicted_valid !== want.ev_valid)
                  flag($sformatf("evicted_valid got %0d want %0d",
                                 rsp_evicted_valid, want.ev_valid));
               if (rsp_evicted_page !== want.ev_page)
                  flag($sformatf("evicted_page got %h want %h",
                                 rsp_evicted_page, want.ev_page));
               if (rsp_occupancy !== want.occ)
                  flag($sformatf("occupancy got %0d want %0d", rsp_occupancy, want.occ));
               if (rsp_hit_total !== want.hits)
                  flag($sformatf("hit_total got %0d want %0d", rsp_hit_total, want.hits));
               if (rsp_fault_total !== want.faults)
                  flag($sformatf("fault_total got %0d want %0d",
                                 rsp_fault_total, want.faults));
            end
         end
         if (req_valid && req_ready) begin
            due_outcomes.insert(due_outcomes.size(), touch_page(req_page_number));
         end
      end
      outstanding <= due_outcomes.size();
   end

endmodule

FILE: sim/lru_page_replacement_stack_core_test.sv
`timescale 1ns / 100ps
// Testbench top for lru_page_replacement_stack_core: drives page references and
// frame-limit writes, stalls the response side, and reports the verdict.
// Depends on lps_pkg, the core and lru_replacement_monitor.
module lru_page_replacement_stack_core_test
   import lps_pkg::*;
();

   localparam int REFS_PER_PHASE = 200;
   localparam int LONG_HOLD      = 300;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int POOL_SLOTS     = 24;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [PAGE_W-1:0]  req_page_number;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_hit;
   logic [DEPTH_W-1:0] rsp_hit_depth;
   logic               rsp_evicted_valid;
   logic [PAGE_W-1:0]  rsp_evicted_page;
   logic [OCC_W-1:0]   rsp_occupancy;
   logic [TOTAL_W-1:0] rsp_hit_total;
   logic [TOTAL_W-1:0] rsp_fault_total;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [ADDR_W-1:0]  paddr;
   logic [DATA_W-1:0]  pwdata;
   logic [DATA_W-1:0]  prdata;
   logic               pready;

   int                 outstanding;
   int                 mismatch_count;
   int                 hits_seen;
   int                 faults_seen;

   int                 cycle_count;
   int                 stall_ticket;
   int                 stall_served;
   int                 refs_sent;
   int                 limits_tried;
   int                 burst_left;
   bit                 gaps_on;
   int                 pool_n;
   logic [PAGE_W-1:0]  page_pool [POOL_SLOTS];

   lru_page_replacement_stack_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_hit_depth     (rsp_hit_depth),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_hit_total     (rsp_hit_total),
      .rsp_fault_total   (rsp_fault_total),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   lru_replacement_monitor u_monitor (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_hit_depth     (rsp_hit_depth),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_hit_total     (rsp_hit_total),
      .rsp_fault_total   (rsp_fault_total),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .pready            (pready),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .outstanding       (outstanding),
      .mismatch_count    (mismatch_count),
      .hits_seen         (hits_seen),
      .faults_seen       (faults_seen)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding", cycle_count, outstanding);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // response side: stall pattern of its own, plus a long hold-off on request
   initial begin
      int span;
      int mode;
      rsp_ready = 1'b0;
      forever begin
         span = $urandom_range(10, 80);
         mode = $urandom_range(0, 2);
         repeat (span) begin
            @(posedge clock);
            if (stall_ticket != stall_served) begin
               rsp_ready <= 1'b0;
               repeat (LONG_HOLD) @(posedge clock);
               stall_served++;
            end else begin
               case (mode)
                  0: rsp_ready <= 1'b1;
                  1: rsp_ready <= 1'($urandom_range(0, 1));
                  default: rsp_ready <= ($urandom_range(0, 3) == 0);
               endcase
            end
         end
      end
   end

   function automatic int frames_effective(input logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_FRAMES_DEF) return MAX_FRAMES_DEF;
      return int'(v);
   endfunction

   function automatic logic [PAGE_W-1:0] pick_page();
      if ($urandom_range(0, 9) < 7) return page_pool[$urandom_range(0, pool_n - 1)];
      return PAGE_W'($urandom_range(0, 65535));
   endfunction

   task automatic offer(input logic [PAGE_W-1:0] page);
      req_valid       <= 1'b1;
      req_page_number <= page;
      do @(posedge clock); while (!req_ready);
      refs_sent++;
      if (gaps_on) begin
         burst_left--;
         if (burst_left <= 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            burst_left = $urandom_range(1, 24);
         end
      end
   endtask

   // drain every pending beat, then allow the pipeline to settle
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_frames(input logic [CFG_W-1:0] v);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {REG_FRAMES, 2'b00};
      pwdata  <= ($urandom() & 32'hFFFF_FFE0) | {{(DATA_W-CFG_W){1'b0}}, v};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      limits_tried++;
   endtask

   task automatic run_phase(input logic [CFG_W-1:0] v, input int count, input bit with_hold);
      int k;
      quiesce();
      set_frames(v);
      pool_n = frames_effective(v) + $urandom_range(0, 5);
      foreach (page_pool[i]) page_pool[i] = PAGE_W'($urandom_range(0, 65535));
      for (k = 0; k < count; k++) begin
         if (with_hold && k == count / 2) stall_ticket++;
         offer(pick_page());
      end
   endtask

   initial begin
      int k;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_page_number = '0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      cycle_count     = 0;
      stall_ticket    = 0;
      stall_served    = 0;
      refs_sent       = 0;
      limits_tried    = 0;
      gaps_on         = 1'b0;
      burst_left      = 1;
      pool_n          = 1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset frame limit of three: hits, fill, evict
      offer(16'h0000);
      offer(16'hFFFF);
      offer(16'h0000);
      offer(16'h5A5A);
      offer(16'hA5A5);
      offer(16'h0000);

      // full sixteen frames, hit at the deepest slot, then evict
      quiesce();
      set_frames(5'd16);
      for (k = 0; k < 16; k++) offer(16'h1000 + PAGE_W'(k) * 16'h0111);
      offer(16'h1000);
      offer(16'hC3C3);

      // limit lowered under occupancy: hit keeps size, fault trims
      quiesce();
      set_frames(5'd2);
      offer(16'h1000);
      offer(16'h7E7E);

      // zero limit behaves as one frame
      quiesce();
      set_frames(5'd0);
      offer(16'h7E7E);
      offer(16'h0001);

      run_phase(5'd16, REFS_PER_PHASE, 1'b0);
      gaps_on    = 1'b1;
      burst_left = $urandom_range(1, 24);
      run_phase(5'd31, REFS_PER_PHASE, 1'b0);
      run_phase(5'd1, REFS_PER_PHASE, 1'b0);
      run_phase(5'd9, REFS_PER_PHASE, 1'b0);
      run_phase(5'd16, REFS_PER_PHASE, 1'b1);
      run_phase(CFG_W'($urandom_range(2, 30)), REFS_PER_PHASE, 1'b0);
      quiesce();

      $display("Covered %0d page references over %0d frame limits, with a long response stall.",
               refs_sent, limits_tried);
      $display("Checked %0d hit beats and %0d fault beats.", hits_seen, faults_seen);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
